FILE: hdl/bpss_pkg.sv
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared types and constants of the battery pack scan supervisor: register
// map, controller states, datapath commands and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bpss_pkg;

   // register map, index = byte address / 4
   typedef enum logic [2:0] {
      REG_CELL_LOW  = 3'd0,
      REG_CELL_HIGH = 3'd1,
      REG_TEMP_HIGH = 3'd2,
      REG_ARRAY_OFF = 3'd3,
      REG_ARRAY_ON  = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic [15:0] CELL_LOW_RST  = 16'd27000;
   localparam logic [15:0] CELL_HIGH_RST = 16'd42000;
   localparam logic [7:0]  TEMP_HIGH_RST = 8'd60;
   localparam logic [15:0] ARRAY_OFF_RST = 16'd41000;
   localparam logic [15:0] ARRAY_ON_RST  = 16'd40000;

   // scan and balance constants
   localparam logic [15:0] MIN_START  = 16'd50000;
   localparam logic [15:0] BAL_MARGIN = 16'd3000;

   // charge arithmetic: q = x / 100000 = ((x >> 5) * RECIP) >> RECIP_SHIFT,
   // low by at most one, then corrected with one compare
   localparam logic [31:0] RECIP       = 32'd351843720;
   localparam int          RECIP_SHIFT = 40;
   localparam logic [31:0] DIVISOR     = 32'd100000;
   localparam logic [31:0] CHG_OFFSET  = 32'd20000;
   localparam logic [31:0] CHG_SCALE   = 32'd288;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [15:0] cell_low;
      logic [15:0] cell_high;
      logic [7:0]  temp_high;
      logic [15:0] array_off;
      logic [15:0] array_on;
   } cfg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_X5,
      ST_REC,
      ST_QM,
      ST_FIX,
      ST_CHG,
      ST_EMIT
   } state_type;

   // datapath step commands
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SQ,
      OP_X5,
      OP_REC,
      OP_QM,
      OP_FIX,
      OP_CHG,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/bpss_csr.sv
// ----------------------------------------------------------------------------
// bpss_csr
// Limit registers behind the APB-style port, written on the access phase.
// ----------------------------------------------------------------------------
`default_nettype none

module bpss_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [4:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output logic                 csr_pready,
   output bpss_pkg::cfg_type    cfg
);

   bpss_pkg::cfg_type     cfg_ff;
   bpss_pkg::cfg_type     cfg_in;
   bpss_pkg::reg_index_type sel;
   logic                  wr_en;

   assign sel   = bpss_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            bpss_pkg::REG_CELL_LOW:  cfg_in.cell_low  = csr_pwdata[15:0];
            bpss_pkg::REG_CELL_HIGH: cfg_in.cell_high = csr_pwdata[15:0];
            bpss_pkg::REG_TEMP_HIGH: cfg_in.temp_high = csr_pwdata[7:0];
            bpss_pkg::REG_ARRAY_OFF: cfg_in.array_off = csr_pwdata[15:0];
            bpss_pkg::REG_ARRAY_ON:  cfg_in.array_on  = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_low  <= bpss_pkg::CELL_LOW_RST;
         cfg_ff.cell_high <= bpss_pkg::CELL_HIGH_RST;
         cfg_ff.temp_high <= bpss_pkg::TEMP_HIGH_RST;
         cfg_ff.array_off <= bpss_pkg::ARRAY_OFF_RST;
         cfg_ff.array_on  <= bpss_pkg::ARRAY_ON_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (sel)
         bpss_pkg::REG_CELL_LOW:  csr_prdata = {16'd0, cfg_ff.cell_low};
         bpss_pkg::REG_CELL_HIGH: csr_prdata = {16'd0, cfg_ff.cell_high};
         bpss_pkg::REG_TEMP_HIGH: csr_prdata = {24'd0, cfg_ff.temp_high};
         bpss_pkg::REG_ARRAY_OFF: csr_prdata = {16'd0, cfg_ff.array_off};
         bpss_pkg::REG_ARRAY_ON:  csr_prdata = {16'd0, cfg_ff.array_on};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/bpss_ctrl.sv
// ----------------------------------------------------------------------------
// bpss_ctrl
// Sequencer: accepts a beat, steps the charge arithmetic on a scan end,
// then loads the result register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bpss_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bpss_pkg::status_type status,
   output bpss_pkg::cmd_type         cmd
);

   bpss_pkg::state_type state_ff;
   bpss_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpss_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.scan_last ? bpss_pkg::ST_SQ : bpss_pkg::ST_EMIT;
            end
         end
         bpss_pkg::ST_SQ:  state_in = bpss_pkg::ST_X5;
         bpss_pkg::ST_X5:  state_in = bpss_pkg::ST_REC;
         bpss_pkg::ST_REC: state_in = bpss_pkg::ST_QM;
         bpss_pkg::ST_QM:  state_in = bpss_pkg::ST_FIX;
         bpss_pkg::ST_FIX: state_in = bpss_pkg::ST_CHG;
         bpss_pkg::ST_CHG: state_in = bpss_pkg::ST_EMIT;
         bpss_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = bpss_pkg::ST_IDLE;
            end
         end
         default: state_in = bpss_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = bpss_pkg::OP_NONE;
      case (state_ff)
         bpss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = req_valid ? bpss_pkg::OP_ACCEPT : bpss_pkg::OP_NONE;
         end
         bpss_pkg::ST_SQ:   cmd.op = bpss_pkg::OP_SQ;
         bpss_pkg::ST_X5:   cmd.op = bpss_pkg::OP_X5;
         bpss_pkg::ST_REC:  cmd.op = bpss_pkg::OP_REC;
         bpss_pkg::ST_QM:   cmd.op = bpss_pkg::OP_QM;
         bpss_pkg::ST_FIX:  cmd.op = bpss_pkg::OP_FIX;
         bpss_pkg::ST_CHG:  cmd.op = bpss_pkg::OP_CHG;
         bpss_pkg::ST_EMIT: cmd.op = out_free ? bpss_pkg::OP_EMIT : bpss_pkg::OP_NONE;
         default:           cmd.op = bpss_pkg::OP_NONE;
      endcase
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == bpss_pkg::ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/bpss_dpath.sv
// ----------------------------------------------------------------------------
// bpss_dpath
// Scan state, per-module limit checks, end-of-scan relay and balance logic,
// and the charge arithmetic on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bpss_dpath #(
   parameter int MAX_MODULES = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bpss_pkg::cmd_type    cmd,
   output bpss_pkg::status_type      status,
   input  wire bpss_pkg::cfg_type    cfg,
   input  wire logic [15:0]          req_module_voltage,
   input  wire logic [7:0]           req_module_temp,
   input  wire logic                 req_scan_end,
   output logic      [5:0]           rsp_module_index,
   output logic                      rsp_limit_fault,
   output logic                      rsp_scan_done,
   output logic                      rsp_array_on,
   output logic                      rsp_release_valid,
   output logic      [5:0]           rsp_release_module,
   output logic                      rsp_balance_valid,
   output logic      [5:0]           rsp_balance_module,
   output logic      [31:0]          rsp_charge_estimate
);

   localparam logic [5:0] LAST_POS = 6'(MAX_MODULES - 1);

   // scan state
   logic [5:0]  pos_ff, pos_in;
   logic [15:0] min_v_ff, min_v_in;
   logic [5:0]  min_mod_ff, min_mod_in;
   logic        min_found_ff, min_found_in;
   logic        over_ff, over_in;
   logic        under_ff, under_in;
   logic        relay_ff, relay_in;
   logic        held_v_ff, held_v_in;
   logic [5:0]  held_mod_ff, held_mod_in;

   // per-beat result fields
   logic [5:0]  idx_ff, idx_in;
   logic        fault_ff, fault_in;
   logic        done_ff, done_in;
   logic        rel_v_ff, rel_v_in;
   logic [5:0]  rel_m_ff, rel_m_in;
   logic        bal_v_ff, bal_v_in;
   logic [5:0]  bal_m_ff, bal_m_in;
   logic [15:0] cv_ff, cv_in;

   // charge arithmetic
   logic [63:0] acc_ff, acc_in;
   logic [31:0] x5_ff, x5_in;
   logic [15:0] q_ff, q_in;
   logic [31:0] c_ff, c_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;

   // output register
   logic [5:0]  o_idx_ff, o_idx_in;
   logic        o_fault_ff, o_fault_in;
   logic        o_done_ff, o_done_in;
   logic        o_relay_ff, o_relay_in;
   logic        o_rel_v_ff, o_rel_v_in;
   logic [5:0]  o_rel_m_ff, o_rel_m_in;
   logic        o_bal_v_ff, o_bal_v_in;
   logic [5:0]  o_bal_m_ff, o_bal_m_in;
   logic [31:0] o_chg_ff, o_chg_in;

   // combinational beat evaluation
   logic        fault;
   logic        take_min;
   logic [15:0] new_min;
   logic [5:0]  new_mod;
   logic        new_found;
   logic        over_n;
   logic        under_n;
   logic        relay_n;
   logic [15:0] thresh;
   logic        bal;
   logic [5:0]  bal_mod;
   logic [31:0] rem;
   logic [15:0] q_fix;

   // limit checks and running scan summary
   assign fault = (req_module_voltage < cfg.cell_low) ||
                  (req_module_voltage > cfg.cell_high) ||
                  (req_module_temp > cfg.temp_high);
   assign take_min  = req_module_voltage < min_v_ff;
   assign new_min   = take_min ? req_module_voltage : min_v_ff;
   assign new_mod   = take_min ? pos_ff : min_mod_ff;
   assign new_found = take_min | min_found_ff;
   assign over_n    = over_ff  | (req_module_voltage >= cfg.array_off);
   assign under_n   = under_ff | (req_module_voltage <= cfg.array_on);

   assign status.scan_last = req_scan_end | (pos_ff >= LAST_POS);

   // relay hysteresis: over-level turns it off first
   always_comb begin
      relay_n = relay_ff;
      if (over_n && relay_ff) begin
         relay_n = 1'b0;
      end else if (under_n && !relay_ff) begin
         relay_n = 1'b1;
      end
   end

   // balance choice, threshold saturates at zero
   assign thresh  = (cfg.cell_high >= bpss_pkg::BAL_MARGIN) ?
                    cfg.cell_high - bpss_pkg::BAL_MARGIN : 16'd0;
   assign bal     = (new_min < thresh) && (new_found || held_v_ff);
   assign bal_mod = new_found ? new_mod : held_mod_ff;

   // quotient correction: estimate is at most one low
   assign rem   = x5_ff - acc_ff[31:0];
   assign q_fix = (rem >= bpss_pkg::DIVISOR) ? q_ff + 16'd1 : q_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (cmd.op)
         bpss_pkg::OP_SQ: begin
            mul_a = {16'd0, cv_ff};
            mul_b = {16'd0, cv_ff};
         end
         bpss_pkg::OP_REC: begin
            mul_a = {5'd0, x5_ff[31:5]};
            mul_b = bpss_pkg::RECIP;
         end
         bpss_pkg::OP_QM: begin
            mul_a = {16'd0, acc_ff[bpss_pkg::RECIP_SHIFT +: 16]};
            mul_b = bpss_pkg::DIVISOR;
         end
         bpss_pkg::OP_CHG: begin
            mul_a = c_ff;
            mul_b = bpss_pkg::CHG_SCALE;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // next values per command
   always_comb begin
      pos_in       = pos_ff;
      min_v_in     = min_v_ff;
      min_mod_in   = min_mod_ff;
      min_found_in = min_found_ff;
      over_in      = over_ff;
      under_in     = under_ff;
      relay_in     = relay_ff;
      held_v_in    = held_v_ff;
      held_mod_in  = held_mod_ff;
      idx_in       = idx_ff;
      fault_in     = fault_ff;
      done_in      = done_ff;
      rel_v_in     = rel_v_ff;
      rel_m_in     = rel_m_ff;
      bal_v_in     = bal_v_ff;
      bal_m_in     = bal_m_ff;
      cv_in        = cv_ff;
      acc_in       = acc_ff;
      x5_in        = x5_ff;
      q_in         = q_ff;
      c_in         = c_ff;
      o_idx_in     = o_idx_ff;
      o_fault_in   = o_fault_ff;
      o_done_in    = o_done_ff;
      o_relay_in   = o_relay_ff;
      o_rel_v_in   = o_rel_v_ff;
      o_rel_m_in   = o_rel_m_ff;
      o_bal_v_in   = o_bal_v_ff;
      o_bal_m_in   = o_bal_m_ff;
      o_chg_in     = o_chg_ff;
      case (cmd.op)
         bpss_pkg::OP_ACCEPT: begin
            idx_in   = pos_ff;
            fault_in = fault;
            done_in  = status.scan_last;
            if (status.scan_last) begin
               relay_in     = relay_n;
               rel_v_in     = held_v_ff;
               rel_m_in     = held_v_ff ? held_mod_ff : 6'd0;
               held_v_in    = bal;
               held_mod_in  = bal ? bal_mod : 6'd0;
               bal_v_in     = bal;
               bal_m_in     = bal ? bal_mod : 6'd0;
               cv_in        = new_min;
               pos_in       = 6'd0;
               min_v_in     = bpss_pkg::MIN_START;
               min_mod_in   = 6'd0;
               min_found_in = 1'b0;
               over_in      = 1'b0;
               under_in     = 1'b0;
            end else begin
               pos_in       = pos_ff + 6'd1;
               min_v_in     = new_min;
               min_mod_in   = new_mod;
               min_found_in = new_found;
               over_in      = over_n;
               under_in     = under_n;
            end
         end
         bpss_pkg::OP_SQ:  acc_in = 64'(mul_a) * 64'(mul_b);
         bpss_pkg::OP_X5:  x5_in  = acc_ff[31:0] + {acc_ff[29:0], 2'b00};
         bpss_pkg::OP_REC: acc_in = 64'(mul_a) * 64'(mul_b);
         bpss_pkg::OP_QM: begin
            q_in   = acc_ff[bpss_pkg::RECIP_SHIFT +: 16];
            acc_in = 64'(mul_a) * 64'(mul_b);
         end
         bpss_pkg::OP_FIX: begin
            c_in = {16'd0, q_fix} - {15'd0, cv_ff, 1'b0} + bpss_pkg::CHG_OFFSET;
         end
         bpss_pkg::OP_CHG: acc_in = 64'(mul_a) * 64'(mul_b);
         bpss_pkg::OP_EMIT: begin
            o_idx_in   = idx_ff;
            o_fault_in = fault_ff;
            o_done_in  = done_ff;
            o_relay_in = done_ff & relay_ff;
            o_rel_v_in = done_ff & rel_v_ff;
            o_rel_m_in = done_ff ? rel_m_ff : 6'd0;
            o_bal_v_in = done_ff & bal_v_ff;
            o_bal_m_in = done_ff ? bal_m_ff : 6'd0;
            o_chg_in   = done_ff ? acc_ff[31:0] : 32'd0;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // scan and relay state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 6'd0;
         min_v_ff     <= bpss_pkg::MIN_START;
         min_mod_ff   <= 6'd0;
         min_found_ff <= 1'b0;
         over_ff      <= 1'b0;
         under_ff     <= 1'b0;
         relay_ff     <= 1'b0;
         held_v_ff    <= 1'b0;
         held_mod_ff  <= 6'd0;
      end else begin
         pos_ff       <= pos_in;
         min_v_ff     <= min_v_in;
         min_mod_ff   <= min_mod_in;
         min_found_ff <= min_found_in;
         over_ff      <= over_in;
         under_ff     <= under_in;
         relay_ff     <= relay_in;
         held_v_ff    <= held_v_in;
         held_mod_ff  <= held_mod_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      fault_ff   <= fault_in;
      done_ff    <= done_in;
      rel_v_ff   <= rel_v_in;
      rel_m_ff   <= rel_m_in;
      bal_v_ff   <= bal_v_in;
      bal_m_ff   <= bal_m_in;
      cv_ff      <= cv_in;
      acc_ff     <= acc_in;
      x5_ff      <= x5_in;
      q_ff       <= q_in;
      c_ff       <= c_in;
      o_idx_ff   <= o_idx_in;
      o_fault_ff <= o_fault_in;
      o_done_ff  <= o_done_in;
      o_relay_ff <= o_relay_in;
      o_rel_v_ff <= o_rel_v_in;
      o_rel_m_ff <= o_rel_m_in;
      o_bal_v_ff <= o_bal_v_in;
      o_bal_m_ff <= o_bal_m_in;
      o_chg_ff   <= o_chg_in;
   end

   assign rsp_module_index    = o_idx_ff;
   assign rsp_limit_fault     = o_fault_ff;
   assign rsp_scan_done       = o_done_ff;
   assign rsp_array_on        = o_relay_ff;
   assign rsp_release_valid   = o_rel_v_ff;
   assign rsp_release_module  = o_rel_m_ff;
   assign rsp_balance_valid   = o_bal_v_ff;
   assign rsp_balance_module  = o_bal_m_ff;
   assign rsp_charge_estimate = o_chg_ff;

endmodule

`default_nettype wire

FILE: hdl/battery_pack_scan_supervisor_top.sv
// ----------------------------------------------------------------------------
// battery_pack_scan_supervisor_top
// Per-module limit checks over a pack scan, with end-of-scan relay
// hysteresis, balance module selection and state-of-charge estimate.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     voltage, temp, scan_end
//   rsp       out        rsp_valid / rsp_ready     index, fault, scan summary
//   csr       in/out     psel/penable, pready = 1  five limit registers
//
// A beat that does not end a scan is accepted, then loaded into the result
// register. A scan-ending beat is accepted, runs six steps of the charge
// arithmetic, four of them on the one shared 32x32 multiplier, and is loaded.
// The result register frees req as soon as it is loaded; a stalled rsp holds
// the next result in the sequencer until it is taken.
// Reset is synchronous and restores the register defaults and a fresh scan.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_pack_scan_supervisor_top #(
   parameter int MAX_MODULES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_module_voltage,
   input  wire logic [7:0]  req_module_temp,
   input  wire logic        req_scan_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_module_index,
   output logic             rsp_limit_fault,
   output logic             rsp_scan_done,
   output logic             rsp_array_on,
   output logic             rsp_release_valid,
   output logic [5:0]       rsp_release_module,
   output logic             rsp_balance_valid,
   output logic [5:0]       rsp_balance_module,
   output logic [31:0]      rsp_charge_estimate,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   bpss_pkg::cfg_type    cfg;
   bpss_pkg::cmd_type    cmd;
   bpss_pkg::status_type status;

   // limit registers
   bpss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   bpss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   bpss_dpath #(
      .MAX_MODULES (MAX_MODULES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg                 (cfg),
      .req_module_voltage  (req_module_voltage),
      .req_module_temp     (req_module_temp),
      .req_scan_end        (req_scan_end),
      .rsp_module_index    (rsp_module_index),
      .rsp_limit_fault     (rsp_limit_fault),
      .rsp_scan_done       (rsp_scan_done),
      .rsp_array_on        (rsp_array_on),
      .rsp_release_valid   (rsp_release_valid),
      .rsp_release_module  (rsp_release_module),
      .rsp_balance_valid   (rsp_balance_valid),
      .rsp_balance_module  (rsp_balance_module),
      .rsp_charge_estimate (rsp_charge_estimate)
   );

   // one beat in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is still in flight");

   // summary fields are zero outside a scan end
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scan_done |-> !rsp_array_on && !rsp_release_valid &&
         !rsp_balance_valid && rsp_charge_estimate == 32'd0)
      else $error("summary field set on a beat that does not end a scan");

   // module fields are zero without their valid
   a_module_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_balance_valid || rsp_balance_module == 6'd0) &&
         (rsp_release_valid || rsp_release_module == 6'd0))
      else $error("module index reported without its valid");

   // scan position stays inside the pack
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_module_index <= 6'(MAX_MODULES - 1))
      else $error("module index beyond the last module");

endmodule

`default_nettype wire

FILE: test/battery_pack_scan_supervisor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_pack_scan_supervisor_top_test
// Self-checking bench for the pack scan supervisor. A directed run covers
// the limit edges, ties for the lowest module, relay hysteresis, keeping the
// held balance module and a saturated balance threshold. Random scans then
// follow under several limit settings. Both channels idle at random, and the
// result side holds off once for a long stretch. Every result beat is checked
// field by field against a cycle-free predictor of the scan logic.
// ----------------------------------------------------------------------------
module battery_pack_scan_supervisor_top_test;

   localparam int MAX_MODULES    = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_READINGS = 125;
   localparam logic [15:0] SCAN_MIN_START = 16'd50000;
   localparam logic [15:0] BALANCE_MARGIN = 16'd3000;

   typedef struct packed {
      logic [15:0] voltage;
      logic [7:0]  temp;
      logic        scan_end;
   } reading_type;

   typedef struct packed {
      logic [5:0]  module_index;
      logic        limit_fault;
      logic        scan_done;
      logic        array_on;
      logic        release_valid;
      logic [5:0]  release_module;
      logic        balance_valid;
      logic [5:0]  balance_module;
      logic [31:0] charge_estimate;
   } scan_result_type;

   // dut signals, all known from time zero
   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_module_voltage = '0;
   logic [7:0]  req_module_temp = '0;
   logic        req_scan_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_module_index;
   logic        rsp_limit_fault;
   logic        rsp_scan_done;
   logic        rsp_array_on;
   logic        rsp_release_valid;
   logic [5:0]  rsp_release_module;
   logic        rsp_balance_valid;
   logic [5:0]  rsp_balance_module;
   logic [31:0] rsp_charge_estimate;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // limit copies held by the predictor
   logic [15:0] lim_cell_low  = 16'd27000;
   logic [15:0] lim_cell_high = 16'd42000;
   logic [7:0]  lim_temp_high = 8'd60;
   logic [15:0] lim_array_off = 16'd41000;
   logic [15:0] lim_array_on  = 16'd40000;

   // scan state held by the predictor
   logic [5:0]  scan_pos = '0;
   logic [15:0] low_volt = SCAN_MIN_START;
   logic [5:0]  low_module = '0;
   logic        low_found = 1'b0;
   logic        over_hit = 1'b0;
   logic        under_hit = 1'b0;
   logic        relay_on = 1'b0;
   logic        bal_held = 1'b0;
   logic [5:0]  bal_held_module = '0;

   reading_type     readings_pending[$];
   scan_result_type results_due[$];
   reading_type     next_reading;
   scan_result_type got_result;
   scan_result_type want_result;

   int mismatches = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_started = 0;
   bit steady_send = 1'b0;
   bit steady_recv = 1'b0;
   bit req_beat_done = 1'b0;
   bit rsp_beat_done = 1'b0;

   battery_pack_scan_supervisor_top #(
      .MAX_MODULES(MAX_MODULES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_module_voltage(req_module_voltage),
      .req_module_temp(req_module_temp),
      .req_scan_end(req_scan_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_module_index(rsp_module_index),
      .rsp_limit_fault(rsp_limit_fault),
      .rsp_scan_done(rsp_scan_done),
      .rsp_array_on(rsp_array_on),
      .rsp_release_valid(rsp_release_valid),
      .rsp_release_module(rsp_release_module),
      .rsp_balance_valid(rsp_balance_valid),
      .rsp_balance_module(rsp_balance_module),
      .rsp_charge_estimate(rsp_charge_estimate),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // state of charge from the scan minimum, all in 32-bit wrapping math
   function automatic logic [31:0] charge_for(input logic [15:0] v);
      logic [31:0] wide;
      logic [31:0] soc;
      wide = {16'd0, v};
      soc = (wide * wide * 32'd5) / 32'd100000;
      soc = soc - (wide << 1) + 32'd20000;
      return soc * 32'd288;
   endfunction

   // one reading through the scan logic, updating the predicted state
   function automatic scan_result_type scan_step(input reading_type rd);
      scan_result_type res;
      logic [5:0]   pos;
      logic [15:0]  thresh;
      logic         choose;
      logic [5:0]   pick;
      res = '0;
      pos = scan_pos;
      res.module_index = pos;
      res.limit_fault = (rd.voltage < lim_cell_low) || (rd.voltage > lim_cell_high)
                        || (rd.temp > lim_temp_high);
      // strictly lower only, so the first of equal readings wins
      if (rd.voltage < low_volt) begin
         low_volt = rd.voltage;
         low_module = pos;
         low_found = 1'b1;
      end
      if (rd.voltage >= lim_array_off) over_hit = 1'b1;
      if (rd.voltage <= lim_array_on) under_hit = 1'b1;
      if (rd.scan_end || pos >= MAX_MODULES - 1) begin
         thresh = (lim_cell_high >= BALANCE_MARGIN) ? lim_cell_high - BALANCE_MARGIN : '0;
         // relay hysteresis, turning off wins
         if (over_hit && relay_on) begin
            relay_on = 1'b0;
         end else if (under_hit && !relay_on) begin
            relay_on = 1'b1;
         end
         res.scan_done = 1'b1;
         res.array_on = relay_on;
         res.release_valid = bal_held;
         res.release_module = bal_held ? bal_held_module : '0;
         // no new minimum keeps the held module
         choose = (low_volt < thresh) && (low_found || bal_held);
         pick = low_found ? low_module : bal_held_module;
         bal_held = choose;
         bal_held_module = choose ? pick : '0;
         res.balance_valid = choose;
         res.balance_module = choose ? pick : '0;
         res.charge_estimate = charge_for(low_volt);
         scan_pos = '0;
         low_volt = SCAN_MIN_START;
         low_module = '0;
         low_found = 1'b0;
         over_hit = 1'b0;
         under_hit = 1'b0;
      end else begin
         scan_pos = pos + 6'd1;
      end
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // voltages clustered around the limits, the 50000 start and full range
   function automatic logic [15:0] pick_voltage();
      int unsigned r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 50) v = $urandom_range(30000, 45000);
      else if (r < 70) v = $urandom_range(38000, 43000);
      else if (r < 82) v = $urandom_range(48000, 52000);
      else v = $urandom_range(0, 65535);
      return v[15:0];
   endfunction

   function automatic logic [7:0] pick_temp();
      int unsigned t;
      t = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 90) : $urandom_range(0, 255);
      return t[7:0];
   endfunction

   task automatic add_reading(input logic [15:0] v, input logic [7:0] t, input logic e);
      readings_pending.push_back(reading_type'{v, t, e});
   endtask

   // a scan of random readings; open scans run on into the next one
   task automatic queue_scan(input int len, input bit close);
      logic last;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1) ? close : ($urandom_range(0, 49) == 0);
         add_reading(pick_voltage(), pick_temp(), last);
      end
   endtask

   // write one limit register, then read it back
   task automatic csr_write(input bpss_pkg::reg_index_type idx, input logic [15:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {16'd0, value}) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("register %s readback: expected %0d, got %0d",
                     idx.name(), value, readback);
      end
      case (idx)
         bpss_pkg::REG_CELL_LOW:  lim_cell_low = value;
         bpss_pkg::REG_CELL_HIGH: lim_cell_high = value;
         bpss_pkg::REG_TEMP_HIGH: lim_temp_high = value[7:0];
         bpss_pkg::REG_ARRAY_OFF: lim_array_off = value;
         bpss_pkg::REG_ARRAY_ON:  lim_array_on = value;
         default: ;
      endcase
   endtask

   task automatic apply_limits(input logic [15:0] low, input logic [15:0] high,
                               input logic [7:0] temp, input logic [15:0] off,
                               input logic [15:0] on);
      csr_write(bpss_pkg::REG_CELL_LOW, low);
      csr_write(bpss_pkg::REG_CELL_HIGH, high);
      csr_write(bpss_pkg::REG_TEMP_HIGH, {8'd0, temp});
      csr_write(bpss_pkg::REG_ARRAY_OFF, off);
      csr_write(bpss_pkg::REG_ARRAY_ON, on);
   endtask

   // block is idle once every queued reading has its result back
   task automatic wait_for_results();
      while (readings_pending.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input scan_result_type exp,
                                input scan_result_type act);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s: expected idx %0d flt %0b done %0b on %0b rel %0b/%0d bal %0b/%0d chg %0d",
                  what, exp.module_index, exp.limit_fault, exp.scan_done, exp.array_on,
                  exp.release_valid, exp.release_module, exp.balance_valid,
                  exp.balance_module, exp.charge_estimate);
         $display("%s: actual   idx %0d flt %0b done %0b on %0b rel %0b/%0d bal %0b/%0d chg %0d",
                  what, act.module_index, act.limit_fault, act.scan_done, act.array_on,
                  act.release_valid, act.release_module, act.balance_valid,
                  act.balance_module, act.charge_estimate);
      end
   endtask

   // reading driver, fed from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat_done) begin
         // beat still offered, hold it
      end else begin
         req_beat_done = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (readings_pending.size() > 0) begin
            next_reading = readings_pending.pop_front();
            req_module_voltage <= next_reading.voltage;
            req_module_temp <= next_reading.temp;
            req_scan_end <= next_reading.scan_end;
            req_valid <= 1'b1;
            send_gap = steady_send ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side ready, with random gaps and the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_started != hold_requests) begin
         holds_started++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_beat_done) begin
            rsp_beat_done = 1'b0;
            recv_gap = steady_recv ? 0 : idle_length();
         end
      end
   end

   // monitor: predict on accepted readings, check result beats, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (req_valid && req_ready) begin
            results_due.push_back(scan_step(reading_type'{req_module_voltage,
                                                          req_module_temp,
                                                          req_scan_end}));
            req_beat_done = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_beat_done = 1'b1;
            got_result = '{rsp_module_index, rsp_limit_fault, rsp_scan_done,
                           rsp_array_on, rsp_release_valid, rsp_release_module,
                           rsp_balance_valid, rsp_balance_module, rsp_charge_estimate};
            if (results_due.size() == 0) begin
               flag_mismatch("unexpected beat", '0, got_result);
            end else begin
               want_result = results_due.pop_front();
               if (got_result !== want_result)
                  flag_mismatch("result mismatch", want_result, got_result);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      int len;
      int count;
      bit close;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limit edges at reset settings; under and over in one scan, relay turns on
      add_reading(16'd0, 8'd0, 1'b0);
      add_reading(16'd65535, 8'd255, 1'b0);
      add_reading(16'd26999, 8'd60, 1'b0);
      add_reading(16'd27000, 8'd61, 1'b0);
      add_reading(16'd42000, 8'd60, 1'b0);
      add_reading(16'd42001, 8'd60, 1'b1);
      // nothing below 50000, over level turns the relay off, release module 0
      add_reading(16'd50000, 8'd10, 1'b0);
      add_reading(16'd60000, 8'd10, 1'b1);
      // tie for the lowest module, first one wins
      add_reading(16'd36000, 8'd20, 1'b0);
      add_reading(16'd35000, 8'd20, 1'b0);
      add_reading(16'd35000, 8'd20, 1'b1);
      // single-reading scans right on the array levels
      add_reading(16'd41000, 8'd30, 1'b1);
      add_reading(16'd40000, 8'd30, 1'b1);
      wait_for_results();

      // high threshold above the scan start: held module kept with no new minimum
      csr_write(bpss_pkg::REG_CELL_HIGH, 16'd65535);
      add_reading(16'd45000, 8'd0, 1'b1);
      add_reading(16'd55000, 8'd0, 1'b0);
      add_reading(16'd50000, 8'd0, 1'b1);
      wait_for_results();

      // small high limit saturates the threshold, other limits at the far ends
      apply_limits(16'd0, 16'd2999, 8'd255, 16'd0, 16'd65535);
      add_reading(16'd100, 8'd0, 1'b1);
      queue_scan(20, 1'b1);
      wait_for_results();
      apply_limits(16'd65535, 16'd3000, 8'd0, 16'd65535, 16'd0);
      queue_scan(32, 1'b0);
      queue_scan(10, 1'b1);
      wait_for_results();

      // random scans under random limits
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if ($urandom_range(0, 4) == 0)
            apply_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
         else
            apply_limits(16'($urandom_range(25000, 30000)),
                         16'(($urandom_range(0, 3) == 0) ? $urandom_range(50000, 65535)
                                                         : $urandom_range(40000, 46000)),
                         8'($urandom_range(40, 80)), 16'($urandom_range(39000, 43000)),
                         16'($urandom_range(37000, 41000)));
         steady_send = ($urandom_range(0, 3) == 0);
         steady_recv = ($urandom_range(0, 3) == 0);
         count = 0;
         while (count < PHASE_READINGS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 12);
               7, 8: len = $urandom_range(13, 31);
               default: len = MAX_MODULES;
            endcase
            close = (len == MAX_MODULES) ? ($urandom_range(0, 1) != 0)
                                         : ($urandom_range(0, 19) != 0);
            queue_scan(len, close);
            count += len;
         end
         // long result stall while readings keep coming
         if (ph == 2) hold_requests++;
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
